[rtl/core/kac_pkg.sv]
// Shared types and constants of the k-means assignment and accumulation core.
// Used by kac_cell and kmeans_assign_accumulate_core; depends on nothing.
`default_nettype none

package kac_pkg;

	// Default sizes, handed to the top level parameters.
	localparam int KAC_NUM_CLUSTERS = 10;
	localparam int KAC_NUM_DIMS     = 4;
	localparam int KAC_COORD_WIDTH  = 16;

	// Fixed result field widths.
	localparam int KAC_SUM_W   = 32;
	localparam int KAC_COUNT_W = 16;
	localparam int KAC_DIST_W  = 35;
	localparam int KAC_IDX_W   = 4;
	localparam int KAC_ACT_W   = 4;

	localparam logic [KAC_DIST_W-1:0] KAC_DIST_MAX     = '1;
	localparam logic [KAC_ACT_W-1:0]  KAC_ACTIVE_RESET = 4'd10;

	typedef enum logic [1:0] {
		ACT_LOAD     = 2'd0,
		ACT_CLEAR    = 2'd1,
		ACT_CLASSIFY = 2'd2,
		ACT_READ     = 2'd3
	} kac_action_t;

	localparam logic KIND_ASSIGN = 1'b0;
	localparam logic KIND_TOTALS = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_EMIT
	} kac_state_t;

	// Per-cell commands from the sequencer.
	typedef struct packed {
		logic en;     // cell takes part in the nearest-centroid search
		logic load;   // write the centroid
		logic clear;  // zero sums and count
		logic add;    // accumulate the current point
	} kac_cmd_t;

endpackage

`default_nettype wire

[rtl/core/kac_cell.sv]
// One cluster cell: centroid, saturating sums and count, and a two-stage distance step.
// Depends on kac_pkg.
`default_nettype none

module kac_cell import kac_pkg::*; #(
	parameter int CW = KAC_COORD_WIDTH,
	parameter int ND = KAC_NUM_DIMS,
	parameter int IW = 4,
	parameter int DW = 2 * KAC_COORD_WIDTH + 4,
	parameter logic [IW-1:0] ID = '0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  kac_cmd_t                    cmd,
	input  logic signed [CW-1:0]        ld_coord  [ND],
	input  logic signed [CW-1:0]        add_coord [ND],
	input  logic                        tv_in,
	input  logic signed [CW-1:0]        tpt_in    [ND],
	input  logic [IW-1:0]               tbest_in,
	input  logic [DW-1:0]               tdist_in,
	output logic                        tv_out,
	output logic signed [CW-1:0]        tpt_out   [ND],
	output logic [IW-1:0]               tbest_out,
	output logic [DW-1:0]               tdist_out,
	output logic [KAC_COUNT_W-1:0]      count,
	output logic signed [KAC_SUM_W-1:0] sums      [ND]
);

	localparam int AD_W = CW + 1;
	localparam int SQ_W = 2 * CW + 2;

	logic signed [CW-1:0]        cent_q  [ND];
	logic signed [KAC_SUM_W-1:0] sums_q  [ND];
	logic [KAC_COUNT_W-1:0]      count_q;

	logic signed [AD_W-1:0] diff  [ND];
	logic [AD_W-1:0]        absd  [ND];
	logic [SQ_W-1:0]        sq    [ND];

	logic                   v_s1;
	logic signed [CW-1:0]   pt_s1   [ND];
	logic [IW-1:0]          best_s1;
	logic [DW-1:0]          dist_s1;
	logic [SQ_W-1:0]        sq_s1   [ND];

	logic [DW-1:0]          dsum;
	logic                   take;

	logic signed [KAC_SUM_W:0] sadd [ND];

	// Stage one: per-dimension squared differences against the stored centroid.
	always_comb begin
		for (int j = 0; j < ND; j++) begin
			diff[j] = AD_W'(tpt_in[j]) - AD_W'(cent_q[j]);
			absd[j] = diff[j][AD_W-1] ? AD_W'(-diff[j]) : AD_W'(diff[j]);
			sq[j]   = absd[j] * absd[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			tv_out <= 1'b0;
		end else begin
			v_s1   <= tv_in;
			tv_out <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		pt_s1   <= tpt_in;
		best_s1 <= tbest_in;
		dist_s1 <= tdist_in;
		sq_s1   <= sq;
	end

	// Stage two: total distance and strict compare, so the lower index keeps a tie.
	always_comb begin
		dsum = '0;
		for (int j = 0; j < ND; j++) begin
			dsum = dsum + DW'(sq_s1[j]);
		end
		take = cmd.en && (dsum < dist_s1);
	end

	always_ff @(posedge clk) begin
		tpt_out   <= pt_s1;
		tbest_out <= take ? ID : best_s1;
		tdist_out <= take ? dsum : dist_s1;
	end

	always_comb begin
		for (int j = 0; j < ND; j++) begin
			sadd[j] = {sums_q[j][KAC_SUM_W-1], sums_q[j]}
				+ {{(KAC_SUM_W + 1 - CW){add_coord[j][CW-1]}}, add_coord[j]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < ND; j++) begin
				cent_q[j] <= '0;
				sums_q[j] <= '0;
			end
			count_q <= '0;
		end else begin
			if (cmd.load) begin
				cent_q <= ld_coord;
			end
			if (cmd.clear) begin
				for (int j = 0; j < ND; j++) begin
					sums_q[j] <= '0;
				end
				count_q <= '0;
			end else if (cmd.add) begin
				for (int j = 0; j < ND; j++) begin
					if (sadd[j][KAC_SUM_W] != sadd[j][KAC_SUM_W-1]) begin
						sums_q[j] <= sadd[j][KAC_SUM_W] ?
							{1'b1, {(KAC_SUM_W-1){1'b0}}} : {1'b0, {(KAC_SUM_W-1){1'b1}}};
					end else begin
						sums_q[j] <= sadd[j][KAC_SUM_W-1:0];
					end
				end
				if (count_q != '1) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	assign count = count_q;
	assign sums  = sums_q;

endmodule

`default_nettype wire

[rtl/core/kmeans_assign_accumulate_core.sv]
// Top level of the k-means assignment and accumulation core: sequencer, chain of cluster
// cells, result register and configuration register. Depends on kac_pkg and kac_cell.
//
//   Channel   Signals                                   Direction   Handshake
//   input     action, cluster_index, coord0..coord3     in          in_valid / in_ready
//   result    result_kind ... sum3                      out         out_valid / out_ready
//   config    cfg_wdata (active_clusters)               in          cfg_we, no wait
//
// A load or clear beat completes on its accepting edge; a read beat moves to the emit state, and
// its result register loads from there once it is empty or being taken. A classify beat walks
// the chain, two register stages per cell (squared differences, then sum and compare), and
// its result loads from the emit state once the point has left the last cell.
// The block takes one beat at a time; a waiting result does not block the next beat
// until that beat itself has a result to deliver.
// Reset sets active_clusters to ten and clears centroids, sums and counts at once.
`default_nettype none

module kmeans_assign_accumulate_core import kac_pkg::*; #(
	parameter int NUM_CLUSTERS = KAC_NUM_CLUSTERS,
	parameter int NUM_DIMS     = KAC_NUM_DIMS,
	parameter int COORD_WIDTH  = KAC_COORD_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    action,
	input  logic [KAC_IDX_W-1:0]          cluster_index,
	input  logic signed [COORD_WIDTH-1:0] coord0,
	input  logic signed [COORD_WIDTH-1:0] coord1,
	input  logic signed [COORD_WIDTH-1:0] coord2,
	input  logic signed [COORD_WIDTH-1:0] coord3,
	input  logic                          cfg_we,
	input  logic [KAC_ACT_W-1:0]          cfg_wdata,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          result_kind,
	output logic [KAC_IDX_W-1:0]          assigned_cluster,
	output logic [KAC_DIST_W-1:0]         min_distance,
	output logic [KAC_COUNT_W-1:0]        member_count,
	output logic signed [KAC_SUM_W-1:0]   sum0,
	output logic signed [KAC_SUM_W-1:0]   sum1,
	output logic signed [KAC_SUM_W-1:0]   sum2,
	output logic signed [KAC_SUM_W-1:0]   sum3
);

	localparam int CW   = COORD_WIDTH;
	localparam int ND   = NUM_DIMS;
	localparam int NC   = NUM_CLUSTERS;
	localparam int IW   = (NC > 1) ? $clog2(NC) : 1;
	localparam int IWX  = (IW > KAC_IDX_W) ? IW : KAC_IDX_W;
	localparam int DW   = 2 * CW + 4;
	localparam int DWX  = (DW > KAC_DIST_W) ? DW : KAC_DIST_W;

	// Sequencer state.
	kac_state_t   state_q, state_d;
	kac_action_t  act_q;
	logic [KAC_IDX_W-1:0] idx_q;
	logic signed [CW-1:0] pt_q [ND];
	logic         launch_q, launch_d;
	logic [IW-1:0] best_q;
	logic [DW-1:0] dist_q;
	logic [KAC_ACT_W-1:0] active_q;
	logic         accept;
	logic         out_load;
	logic         chain_done;

	// Result register.
	logic                        out_valid_q;
	logic                        kind_q;
	logic [KAC_IDX_W-1:0]        clus_q;
	logic [KAC_DIST_W-1:0]       mdist_q;
	logic [KAC_COUNT_W-1:0]      mcount_q;
	logic signed [KAC_SUM_W-1:0] osum_q [ND];

	// Input coordinates as an array; dimensions beyond NUM_DIMS are ignored.
	logic signed [CW-1:0] coord_in [4];
	logic signed [CW-1:0] ld_coord [ND];

	// Chain of cells: token slots between neighbors.
	logic                 tok_v    [NC+1];
	logic signed [CW-1:0] tok_pt   [NC+1][ND];
	logic [IW-1:0]        tok_best [NC+1];
	logic [DW-1:0]        tok_dist [NC+1];

	kac_cmd_t                    cmd       [NC];
	logic [NC-1:0]               add_vec;
	logic [NC-1:0]               sel;
	logic [KAC_COUNT_W-1:0]      cell_count [NC];
	logic signed [KAC_SUM_W-1:0] cell_sums  [NC][ND];

	logic [KAC_COUNT_W-1:0]      tot_count;
	logic signed [KAC_SUM_W-1:0] tot_sums [ND];
	logic [DWX-1:0]              dist_x;
	logic [KAC_DIST_W-1:0]       dist_sat;
	logic [IWX-1:0]              best_x;
	logic signed [KAC_SUM_W-1:0] sum_f [4];

	assign coord_in[0] = coord0;
	assign coord_in[1] = coord1;
	assign coord_in[2] = coord2;
	assign coord_in[3] = coord3;

	always_comb begin
		for (int j = 0; j < ND; j++) begin
			ld_coord[j] = coord_in[j];
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// The token leaving the last cell carries the winner; the search is then done.
	assign chain_done = (state_q == ST_SEARCH) && tok_v[NC];
	assign out_load   = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			launch_q <= 1'b0;
			active_q <= KAC_ACTIVE_RESET;
		end else begin
			state_q  <= state_d;
			launch_q <= launch_d;
			if (cfg_we) begin
				active_q <= cfg_wdata;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		launch_d = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (kac_action_t'(action))
						ACT_CLASSIFY: begin
							state_d  = ST_SEARCH;
							launch_d = 1'b1;
						end
						ACT_READ: state_d = ST_EMIT;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_SEARCH: begin
				if (chain_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= kac_action_t'(action);
			idx_q <= cluster_index;
			pt_q  <= ld_coord;
		end
		if (chain_done) begin
			best_q <= tok_best[NC];
			dist_q <= tok_dist[NC];
		end
	end

	// The point enters the first cell with an all-ones distance so the first
	// searched cell always wins its compare.
	assign tok_v[0]    = launch_q;
	assign tok_pt[0]   = pt_q;
	assign tok_best[0] = '0;
	assign tok_dist[0] = '1;

	for (genvar i = 0; i < NC; i++) begin : g_cell
		always_comb begin
			cmd[i].en    = (i == 0) || (i < int'(active_q));
			cmd[i].load  = accept && (kac_action_t'(action) == ACT_LOAD)
				&& (int'(cluster_index) == i);
			cmd[i].clear = accept && (kac_action_t'(action) == ACT_CLEAR);
			cmd[i].add   = chain_done && (tok_best[NC] == IW'(i));
			add_vec[i]   = cmd[i].add;
			sel[i]       = (act_q == ACT_READ) ? (int'(idx_q) == i) : (best_q == IW'(i));
		end

		kac_cell #(
			.CW (CW),
			.ND (ND),
			.IW (IW),
			.DW (DW),
			.ID (IW'(i))
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd[i]),
			.ld_coord  (ld_coord),
			.add_coord (pt_q),
			.tv_in     (tok_v[i]),
			.tpt_in    (tok_pt[i]),
			.tbest_in  (tok_best[i]),
			.tdist_in  (tok_dist[i]),
			.tv_out    (tok_v[i+1]),
			.tpt_out   (tok_pt[i+1]),
			.tbest_out (tok_best[i+1]),
			.tdist_out (tok_dist[i+1]),
			.count     (cell_count[i]),
			.sums      (cell_sums[i])
		);
	end

	// Totals of the selected cell; an index past the last cell selects nothing
	// and so reads as zero.
	always_comb begin
		tot_count = '0;
		for (int j = 0; j < ND; j++) begin
			tot_sums[j] = '0;
		end
		for (int i = 0; i < NC; i++) begin
			if (sel[i]) begin
				tot_count = tot_count | cell_count[i];
				for (int j = 0; j < ND; j++) begin
					tot_sums[j] = tot_sums[j] | cell_sums[i][j];
				end
			end
		end
	end

	assign dist_x   = DWX'(dist_q);
	assign dist_sat = (dist_x > DWX'(KAC_DIST_MAX)) ? KAC_DIST_MAX : dist_x[KAC_DIST_W-1:0];
	assign best_x   = IWX'(best_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (act_q == ACT_READ) begin
				kind_q  <= KIND_TOTALS;
				clus_q  <= idx_q;
				mdist_q <= '0;
			end else begin
				kind_q  <= KIND_ASSIGN;
				clus_q  <= best_x[KAC_IDX_W-1:0];
				mdist_q <= dist_sat;
			end
			mcount_q <= tot_count;
			osum_q   <= tot_sums;
		end
	end

	for (genvar j = 0; j < 4; j++) begin : g_sum
		if (j < ND) begin : g_used
			assign sum_f[j] = osum_q[j];
		end else begin : g_unused
			assign sum_f[j] = '0;
		end
	end

	assign out_valid        = out_valid_q;
	assign result_kind      = kind_q;
	assign assigned_cluster = clus_q;
	assign min_distance     = mdist_q;
	assign member_count     = mcount_q;
	assign sum0             = sum_f[0];
	assign sum1             = sum_f[1];
	assign sum2             = sum_f[2];
	assign sum3             = sum_f[3];

	// Only one point is ever in flight along the chain.
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({launch_q, add_vec, tok_v[NC]} & {1'b1, {NC{1'b0}}, 1'b1}))
		else $error("more than one point in the cell chain");

	// A token reaching the end of the chain is only expected during a search.
	a_token_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		tok_v[NC] |-> (state_q == ST_SEARCH))
		else $error("chain output outside of a search");

	// At most one cell accumulates per cycle.
	a_single_add: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(add_vec))
		else $error("several cells accumulate the same point");

	// A classify result shows the winner after this point was counted.
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && (act_q == ACT_CLASSIFY)) |=> (member_count != '0))
		else $error("assigned cluster reports an empty count");

endmodule

`default_nettype wire
